// File: design/crsd_pkg.sv
// ----------------------------------------------------------------------------
// crsd_pkg
// Shared types and constants for the clock replacement core with set dueling.
// ----------------------------------------------------------------------------
package crsd_pkg;

    // Item field widths
    localparam int SET_W    = 12;
    localparam int WAY_W    = 4;
    localparam int TID_W    = 2;
    localparam int POL_W    = 2;
    localparam int LEAD_W   = 6;
    localparam int PSCORE_W = 11;
    localparam int TSCORE_W = 14;
    localparam int ICTR_W   = 12;
    localparam int NUM_THR  = 4;

    // Request kinds carried in tuser
    localparam logic FUNC_VICTIM = 1'b0;
    localparam logic FUNC_UPDATE = 1'b1;

    // Insertion policies
    localparam logic [POL_W-1:0] POL_CLOCK     = 2'd0;
    localparam logic [POL_W-1:0] POL_BIP_RATIO = 2'd1;
    localparam logic [POL_W-1:0] POL_BIP_HALF  = 2'd2;
    localparam logic [POL_W-1:0] POL_TA_BIP    = 2'd3;

    // Leader slot limits for three and four dueling policies
    localparam logic [LEAD_W-1:0] NPOL_THREE = 6'd3;
    localparam logic [LEAD_W-1:0] NPOL_FOUR  = 6'd4;
    localparam logic [LEAD_W-1:0] TA_LEADER  = 6'd3;

    // Score limits and steps
    typedef logic signed [PSCORE_W-1:0] t_pscore;
    typedef logic signed [TSCORE_W-1:0] t_tscore;

    localparam t_pscore PSCORE_MAX  = 11'sh3FF;
    localparam t_pscore PSCORE_MIN  = 11'sh400;
    localparam t_pscore PSCORE_ONE  = 11'sd1;
    localparam t_pscore PSCORE_INC3 = 11'sd2;
    localparam t_pscore PSCORE_INC4 = 11'sd3;
    localparam t_tscore TSCORE_MAX  = 14'sh1FFF;
    localparam t_tscore TSCORE_MIN  = 14'sh2000;
    localparam t_tscore TSCORE_ONE  = 14'sd1;
    localparam t_tscore TSCORE_INC  = 14'sd3;

    // Insertion counter: BIP window length and half-period bit
    localparam logic [ICTR_W-1:0] INS_LEN  = 12'd64;
    localparam int                INS_BIT  = 6;
    localparam int                WRAP_BIT = 11;

    // Top level sequencer
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

    // Miss fill at the clock hand, seen by the duel unit
    typedef struct packed {
        logic              fill;
        logic [LEAD_W-1:0] leader;
        logic [TID_W-1:0]  tid;
    } t_fill_evt;

endpackage

// File: design/crsd_ram.sv
// ----------------------------------------------------------------------------
// crsd_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module crsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/crsd_set_ctl.sv
// ----------------------------------------------------------------------------
// crsd_set_ctl
// Per-set modify step: clock sweep for victim requests, use-bit update for
// hits and miss fills. Works on one set word {hand, use bits} read from RAM.
// ----------------------------------------------------------------------------
module crsd_set_ctl
    import crsd_pkg::*;
#(
    parameter int WAYS = 16
) (
    input  logic [WAYS+$clog2(WAYS)-1:0] i_word,
    input  logic                         i_func,
    input  logic [WAY_W-1:0]             i_way,
    input  logic                         i_hit,
    input  logic                         i_wb,
    input  logic                         i_insert,
    output logic [WAYS+$clog2(WAYS)-1:0] o_word,
    output logic [$clog2(WAYS)-1:0]      o_victim,
    output logic                         o_fill
);

    localparam int HW = $clog2(WAYS);
    localparam int XW = ((HW > WAY_W) ? HW : WAY_W) + 1;

    logic [WAYS-1:0]   use_q;
    logic [HW-1:0]     hand_q;
    logic [2*WAYS-1:0] dbl;
    logic [WAYS-1:0]   rot;
    logic              found;
    logic [HW-1:0]     pos;
    logic [XW-1:0]     gap;
    logic [WAYS-1:0]   clr;
    logic [XW-1:0]     vsum;
    logic              way_ok;
    logic [WAYS-1:0]   way_bit;
    logic              at_hand;

    assign use_q   = i_word[WAYS-1:0];
    assign hand_q  = i_word[WAYS +: HW];
    assign at_hand = (XW'(i_way) == XW'(hand_q));

    // Miss fill only counts on the way under the hand
    assign o_fill  = (i_func == FUNC_UPDATE) && !i_wb && !i_hit && at_hand;

    // Sweep: find first clear use bit at or after the hand
    always_comb begin
        dbl   = {use_q, use_q} >> hand_q;
        rot   = dbl[WAYS-1:0];
        found = 1'b0;
        pos   = '0;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (!rot[i]) begin
                found = 1'b1;
                pos   = HW'(i);
            end
        end
        // Clear every use bit passed; all of them when none was clear
        for (int i = 0; i < WAYS; i++) begin
            if (XW'(i) >= XW'(hand_q)) begin
                gap = XW'(i) - XW'(hand_q);
            end else begin
                gap = XW'(i) + XW'(WAYS) - XW'(hand_q);
            end
            clr[i] = !found || (gap < XW'(pos));
        end
        vsum = XW'(hand_q) + XW'(pos);
        if (vsum >= XW'(WAYS)) begin
            vsum = vsum - XW'(WAYS);
        end
        o_victim = HW'(vsum);
    end

    // Use-bit for the way named by an update; ways beyond the set never change
    always_comb begin
        way_ok  = (XW'(i_way) < XW'(WAYS));
        way_bit = way_ok ? (WAYS'(1) << i_way) : '0;
    end

    // Build the word written back
    always_comb begin
        o_word = i_word;
        if (i_func == FUNC_VICTIM) begin
            o_word = {o_victim, use_q & ~clr};
        end else if (!i_wb) begin
            if (i_hit) begin
                o_word = {hand_q, use_q | way_bit};
            end else if (at_hand && i_insert) begin
                o_word = {hand_q, use_q | way_bit};
            end
        end
    end

endmodule

// File: design/crsd_duel.sv
// ----------------------------------------------------------------------------
// crsd_duel
// Set dueling scores, per-thread insertion counters and thread miss scores.
// Decides whether a miss fill sets its use bit and reports the best policy.
// ----------------------------------------------------------------------------
module crsd_duel
    import crsd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_mode,
    input  t_fill_evt        i_evt,
    output logic             o_insert,
    output logic [POL_W-1:0] o_best
);

    t_pscore           r_ps  [NUM_THR];
    t_pscore           n_ps  [NUM_THR];
    t_tscore           r_ts  [NUM_THR];
    t_tscore           n_ts  [NUM_THR];
    logic [ICTR_W-1:0] r_ctr [NUM_THR];
    logic [ICTR_W-1:0] n_ctr [NUM_THR];

    logic              is_leader;
    logic [POL_W-1:0]  st;
    logic              psat;
    logic              tsat;
    logic [POL_W-1:0]  best;
    logic [POL_W-1:0]  pol;
    logic [ICTR_W-1:0] ctr;
    logic [ICTR_W-1:0] ctr_inc;

    // Policy scores: leader gains, the others lose, all or none
    always_comb begin
        st        = i_evt.leader[POL_W-1:0];
        is_leader = i_evt.leader < (i_mode ? NPOL_FOUR : NPOL_THREE);
        psat      = i_mode ? (r_ps[st] > PSCORE_MAX - PSCORE_INC4)
                           : (r_ps[st] > PSCORE_MAX - PSCORE_INC3);
        for (int j = 0; j < NUM_THR; j++) begin
            if (((j < 3) || i_mode) && (POL_W'(j) != st) && (r_ps[j] == PSCORE_MIN)) begin
                psat = 1'b1;
            end
        end
        for (int j = 0; j < NUM_THR; j++) begin
            n_ps[j] = r_ps[j];
            if (i_evt.fill && is_leader && !psat) begin
                if (POL_W'(j) == st) begin
                    n_ps[j] = r_ps[j] + (i_mode ? PSCORE_INC4 : PSCORE_INC3);
                end else if ((j < 3) || i_mode) begin
                    n_ps[j] = r_ps[j] - PSCORE_ONE;
                end
            end
        end
    end

    // Lowest score among the active policies, first on ties
    always_comb begin
        best = POL_CLOCK;
        for (int j = 1; j < NUM_THR; j++) begin
            if (((j < 3) || i_mode) && (n_ps[j] < n_ps[best])) begin
                best = POL_W'(j);
            end
        end
        o_best = best;
    end

    // Insertion decision for a miss fill
    always_comb begin
        pol = is_leader ? st : best;
        ctr = r_ctr[i_evt.tid];
        case (pol)
            POL_CLOCK:     o_insert = 1'b1;
            POL_BIP_RATIO: o_insert = (ctr < INS_LEN);
            POL_BIP_HALF:  o_insert = !ctr[INS_BIT];
            default:       o_insert = (ctr < INS_LEN) || (r_ts[i_evt.tid] < 0);
        endcase
    end

    // Counter wraps at 4096 in three-policy mode, 2048 in four-policy mode
    always_comb begin
        ctr_inc = ctr + ICTR_W'(1);
        if (i_mode) begin
            ctr_inc[WRAP_BIT] = 1'b0;
        end
        for (int j = 0; j < NUM_THR; j++) begin
            n_ctr[j] = r_ctr[j];
        end
        if (i_evt.fill) begin
            n_ctr[i_evt.tid] = ctr_inc;
        end
    end

    // Thread miss scores: only fills in the thread-aware leader set, in four-policy mode
    always_comb begin
        tsat = (r_ts[i_evt.tid] > TSCORE_MAX - TSCORE_INC);
        for (int j = 0; j < NUM_THR; j++) begin
            if ((TID_W'(j) != i_evt.tid) && (r_ts[j] == TSCORE_MIN)) begin
                tsat = 1'b1;
            end
        end
        for (int j = 0; j < NUM_THR; j++) begin
            n_ts[j] = r_ts[j];
            if (i_evt.fill && i_mode && (i_evt.leader == TA_LEADER) && !tsat) begin
                if (TID_W'(j) == i_evt.tid) begin
                    n_ts[j] = r_ts[j] + TSCORE_INC;
                end else begin
                    n_ts[j] = r_ts[j] - TSCORE_ONE;
                end
            end
        end
    end

    // Hold or advance the duel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NUM_THR; j++) begin
                r_ps[j]  <= '0;
                r_ts[j]  <= '0;
                r_ctr[j] <= '0;
            end
        end else begin
            for (int j = 0; j < NUM_THR; j++) begin
                r_ps[j]  <= n_ps[j];
                r_ts[j]  <= n_ts[j];
                r_ctr[j] <= n_ctr[j];
            end
        end
    end

endmodule

// File: design/clock_replacement_set_dueling_core.sv
// Flow: an accepted item's set word is read from the set RAM, then modified and
// written back in the EXEC state, where its result is loaded into the output
// register; no other item is taken before the write-back, and a stalled output
// register also holds off the input. Reset: synchronous, active low; afterwards
// the set RAM is cleared one entry per cycle while no item is accepted. Scores reset to zero.
// ----------------------------------------------------------------------------
// clock_replacement_set_dueling_core
// Clock replacement with set dueling between bimodal insertion policies.
// Use bits and clock hand of each set live in one RAM word; duel scores and
// insertion counters live in registers.
// ----------------------------------------------------------------------------
module clock_replacement_set_dueling_core
    import crsd_pkg::*;
#(
    parameter int NUM_SETS = 4096,
    parameter int WAYS     = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: four_policy_mode
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    // Input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // set_index[11:0], way_index[15:12],
                                       // thread_id[17:16], is_hit[18],
                                       // is_writeback[19], zero pad[23:20]
    input  logic        s_axis_tuser,  // func[0]
    // Result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata   // victim_way[3:0], best_policy[5:4],
                                       // zero pad[7:6]
);

    localparam int AW = $clog2(NUM_SETS);
    localparam int HW = $clog2(WAYS);
    localparam int DW = WAYS + HW;

    localparam int WAY_LO = SET_W;
    localparam int TID_LO = WAY_LO + WAY_W;
    localparam int HIT_B  = TID_LO + TID_W;
    localparam int WB_B   = HIT_B + 1;

    t_state             r_state;
    t_state             n_state;
    logic               r_mode;
    logic [AW-1:0]      r_clr_addr;

    logic               r_func;
    logic [SET_W-1:0]   r_set;
    logic [WAY_W-1:0]   r_way;
    logic [TID_W-1:0]   r_tid;
    logic               r_hit;
    logic               r_wb;

    logic               r_out_valid;
    logic [WAY_W-1:0]   r_out_victim;
    logic [POL_W-1:0]   r_out_best;

    logic               in_acc;
    logic [SET_W-1:0]   set_red;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [DW-1:0]      ram_wdata;
    logic [DW-1:0]      ram_rdata;
    logic [DW-1:0]      new_word;
    logic [HW-1:0]      victim;
    logic               set_fill;
    logic               insert;
    logic [POL_W-1:0]   best;
    t_fill_evt          evt;

    // Accept only when idle and the output register is free or draining
    assign s_axis_tready = (r_state == ST_IDLE) && (!r_out_valid || m_axis_tready);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // Reduce set_index modulo NUM_SETS by restoring subtraction
    always_comb begin
        set_red = s_axis_tdata[SET_W-1:0];
        for (int k = 6; k >= 0; k--) begin
            if ((NUM_SETS << k) < (1 << SET_W)) begin
                if (set_red >= SET_W'(NUM_SETS << k)) begin
                    set_red = set_red - SET_W'(NUM_SETS << k);
                end
            end
        end
    end

    // Set word store; the FSM keeps read and write of one item apart
    crsd_ram #(
        .WIDTH (DW),
        .DEPTH (NUM_SETS)
    ) u_set_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_acc),
        .i_raddr (AW'(set_red)),
        .o_rdata (ram_rdata)
    );

    crsd_set_ctl #(
        .WAYS (WAYS)
    ) u_set_ctl (
        .i_word   (ram_rdata),
        .i_func   (r_func),
        .i_way    (r_way),
        .i_hit    (r_hit),
        .i_wb     (r_wb),
        .i_insert (insert),
        .o_word   (new_word),
        .o_victim (victim),
        .o_fill   (set_fill)
    );

    // Miss fill event toward the duel unit
    always_comb begin
        evt.fill   = (r_state == ST_EXEC) && set_fill;
        evt.leader = r_set[LEAD_W-1:0] ^ r_set[SET_W-1:LEAD_W];
        evt.tid    = r_tid;
    end

    crsd_duel u_duel (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_mode   (r_mode),
        .i_evt    (evt),
        .o_insert (insert),
        .o_best   (best)
    );

    // Sequencer next state and RAM write control
    always_comb begin
        n_state   = r_state;
        ram_we    = 1'b0;
        ram_waddr = AW'(r_set);
        ram_wdata = new_word;
        unique case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '0;
                if (r_clr_addr == AW'(NUM_SETS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                ram_we  = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Clear sweep address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (r_state == ST_CLEAR) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // Mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    // Capture the item fields on accept
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_func <= s_axis_tuser;
            r_set  <= set_red;
            r_way  <= s_axis_tdata[WAY_LO +: WAY_W];
            r_tid  <= s_axis_tdata[TID_LO +: TID_W];
            r_hit  <= s_axis_tdata[HIT_B];
            r_wb   <= s_axis_tdata[WB_B];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_EXEC) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_EXEC) begin
            r_out_victim <= (r_func == FUNC_VICTIM) ? WAY_W'(victim) : '0;
            r_out_best   <= best;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_best, r_out_victim};

    // Assertions
    a_no_accept_in_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !s_axis_tready)
        else $error("item accepted during set RAM clear");

    a_accept_to_exec : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state == ST_EXEC))
        else $error("accepted item not executed next cycle");

    a_exec_gives_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC) |=> (m_axis_tvalid && (r_state == ST_IDLE)))
        else $error("executed item produced no result");

    a_victim_in_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_EXEC) && (r_func == FUNC_VICTIM)) |-> (int'(victim) < WAYS))
        else $error("victim way beyond set associativity");

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the clock replacement core with set dueling. Drives
// victim requests and access updates on the item stream, predicts every result
// item from a behavioral copy of use bits, clock hands, duel scores and
// insertion counters, and checks each result field by field in order.
// ----------------------------------------------------------------------------
module testbench
    import crsd_pkg::*;
();

    localparam int NUM_SETS      = 4096;
    localparam int WAYS          = 16;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 150;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int HOT_SETS      = 16;

    // One input item and one result item
    typedef struct packed {
        logic             func;
        logic [SET_W-1:0] set;
        logic [WAY_W-1:0] way;
        logic [TID_W-1:0] tid;
        logic             hit;
        logic             wb;
    } t_access;

    typedef struct packed {
        logic [POL_W-1:0] policy;
        logic [WAY_W-1:0] victim;
    } t_victim_result;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic        i_cfg_wdata   = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;  // set_index[11:0], way_index[15:12],
                                      // thread_id[17:16], is_hit[18],
                                      // is_writeback[19], zero pad[23:20]
    logic        s_axis_tuser  = 1'b0; // func[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // victim_way[3:0], best_policy[5:4],
                                      // zero pad[7:6]

    // Predicted replacement state
    logic [WAYS-1:0]   use_map  [NUM_SETS] = '{default: '0};
    logic [WAY_W-1:0]  hand_pos [NUM_SETS] = '{default: '0};
    int                duel_score   [4] = '{default: 0};
    int                thread_score [4] = '{default: 0};
    logic [ICTR_W-1:0] ins_count    [4] = '{default: '0};
    logic              four_pol = 1'b0;

    t_victim_result pending_results[$];
    t_victim_result oldest;
    logic [SET_W-1:0] hot_sets [HOT_SETS];
    int  mismatch_count = 0;
    int  cycle_count    = 0;
    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    bit  hold_off_req   = 1'b0;

    clock_replacement_set_dueling_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 50 MHz clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Count cycles and stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("testbench failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Lowest duel score among active policies, first one on ties
    function automatic logic [POL_W-1:0] lowest_policy();
        logic [POL_W-1:0] b;
        int i;
        b = POL_CLOCK;
        for (i = 1; i < (four_pol ? 4 : 3); i++) begin
            if (duel_score[i] < duel_score[b]) b = i[POL_W-1:0];
        end
        return b;
    endfunction

    // Advance the hand past set use bits, clearing them
    function automatic logic [WAY_W-1:0] sweep_victim(input logic [SET_W-1:0] s);
        logic [WAY_W-1:0] h;
        int n;
        h = hand_pos[s];
        for (n = 0; n <= WAYS; n++) begin
            if (!use_map[s][h]) break;
            use_map[s][h] = 1'b0;
            h = h + 1'b1;
        end
        hand_pos[s] = h;
        return h;
    endfunction

    function automatic void apply_update(input t_access a);
        int npol;
        int slot;
        int i;
        bit sat;
        bit insert;
        logic [POL_W-1:0]  pol;
        logic [ICTR_W-1:0] ctr;
        npol = four_pol ? 4 : 3;
        ctr  = ins_count[a.tid];
        if (a.wb) return;
        if (a.hit) begin
            use_map[a.set][a.way] = 1'b1;
            return;
        end
        if (a.way != hand_pos[a.set]) return;

        // Duel scores move all together or not at all
        slot = int'(a.set[5:0] ^ a.set[11:6]);
        if (slot < npol) begin
            sat = (duel_score[slot] + npol - 1 > int'(PSCORE_MAX));
            for (i = 1; i < npol; i++) begin
                if (duel_score[(slot + i) % npol] - 1 < int'(PSCORE_MIN)) sat = 1'b1;
            end
            if (!sat) begin
                duel_score[slot] += npol - 1;
                for (i = 1; i < npol; i++) duel_score[(slot + i) % npol] -= 1;
            end
        end

        // Insertion: leaders use their own policy, followers the best one
        pol = (slot < npol) ? slot[POL_W-1:0] : lowest_policy();
        case (pol)
            POL_CLOCK:     insert = 1'b1;
            POL_BIP_RATIO: insert = (ctr < INS_LEN);
            POL_BIP_HALF:  insert = !ctr[INS_BIT];
            default:       insert = (ctr < INS_LEN) || (thread_score[a.tid] < 0);
        endcase
        if (insert) use_map[a.set][a.way] = 1'b1;
        ins_count[a.tid] = ICTR_W'((int'(ctr) + 1) % ((four_pol ? 32 : 64) * 64));

        // Thread-aware leader fills move the thread scores
        if (four_pol && slot == int'(TA_LEADER)) begin
            sat = (thread_score[a.tid] + 3 > int'(TSCORE_MAX));
            for (i = 1; i < 4; i++) begin
                if (thread_score[(a.tid + i) % 4] - 1 < int'(TSCORE_MIN)) sat = 1'b1;
            end
            if (!sat) begin
                thread_score[a.tid] += 3;
                for (i = 1; i < 4; i++) thread_score[(a.tid + i) % 4] -= 1;
            end
        end
    endfunction

    function automatic t_victim_result predict_access(input t_access a);
        t_victim_result r;
        r.victim = '0;
        if (a.func == FUNC_VICTIM) r.victim = sweep_victim(a.set);
        else apply_update(a);
        r.policy = lowest_policy();
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic t_access make_access(input logic f, input logic [SET_W-1:0] s,
                                            input logic [WAY_W-1:0] w,
                                            input logic [TID_W-1:0] t,
                                            input logic h, input logic b);
        t_access a;
        a.func = f;
        a.set  = s;
        a.way  = w;
        a.tid  = t;
        a.hit  = h;
        a.wb   = b;
        return a;
    endfunction

    // Random set whose leader slot equals the given policy
    function automatic logic [SET_W-1:0] leader_set(input int slot);
        logic [5:0] hi;
        hi = 6'($urandom_range(63));
        return {hi, hi ^ slot[5:0]};
    endfunction

    // Mostly well-formed traffic on revisited sets, with some noise
    function automatic t_access random_access(input int leader_pct);
        t_access a;
        int pick;
        a = make_access(FUNC_UPDATE, SET_W'($urandom_range(4095)),
                        WAY_W'($urandom_range(15)), TID_W'($urandom_range(3)),
                        1'($urandom_range(1)), 1'($urandom_range(1)));
        if ($urandom_range(99) < 10) begin
            a.func = 1'($urandom_range(1));
            return a;
        end
        if ($urandom_range(99) < leader_pct) a.set = leader_set($urandom_range(3));
        else if ($urandom_range(1) == 1) a.set = hot_sets[$urandom_range(HOT_SETS - 1)];
        a.wb = ($urandom_range(9) == 0);
        pick = $urandom_range(99);
        if (pick < 30) begin
            a.func = FUNC_VICTIM;
        end else if (pick < 65) begin
            a.way = hand_pos[a.set];
            a.hit = 1'b0;
        end else if (pick < 90) begin
            a.hit = 1'b1;
        end else begin
            a.hit = 1'b0;
        end
        return a;
    endfunction

    // Offer one item after random idle cycles, predict it once accepted
    task automatic send_access(input t_access a);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, a.wb, a.hit, a.tid, a.way, a.set};
        s_axis_tuser  <= a.func;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(predict_access(a));
    endtask

    // Hold the input until every expected result is back
    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_policy_mode(input logic m);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        four_pol = m;
        i_cfg_we <= 1'b0;
    endtask

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // Receiver and result check
    // ------------------------------------------------------------------------

    // Stall at random; a requested hold-off is counted here
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result item %h with none expected", m_axis_tdata));
            end else begin
                oldest = pending_results.pop_front();
                if (m_axis_tdata[WAY_W-1:0] != oldest.victim)
                    report_mismatch($sformatf("victim_way %0d, expected %0d",
                                              m_axis_tdata[WAY_W-1:0], oldest.victim));
                if (m_axis_tdata[WAY_W +: POL_W] != oldest.policy)
                    report_mismatch($sformatf("best_policy %0d, expected %0d",
                                              m_axis_tdata[WAY_W +: POL_W], oldest.policy));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Sweep, wrap, ignored updates and field extremes in three-policy mode
    task automatic test_clock_sweep();
        int w;
        write_policy_mode(1'b0);
        send_access(make_access(FUNC_VICTIM, 12'h000, 4'd9, 2'd0, 1'b0, 1'b0));
        send_access(make_access(FUNC_UPDATE, 12'h000, 4'd0, 2'd1, 1'b0, 1'b1));
        send_access(make_access(FUNC_UPDATE, 12'h000, 4'd5, 2'd2, 1'b0, 1'b0));
        send_access(make_access(FUNC_UPDATE, 12'h000, 4'd0, 2'd3, 1'b0, 1'b0));
        send_access(make_access(FUNC_VICTIM, 12'h000, 4'd15, 2'd3, 1'b1, 1'b1));
        send_access(make_access(FUNC_UPDATE, 12'h000, 4'd1, 2'd0, 1'b1, 1'b1));
        // Fill every use bit, then sweep all the way around
        for (w = 0; w < WAYS; w++)
            send_access(make_access(FUNC_UPDATE, 12'hFFF, w[WAY_W-1:0], w[TID_W-1:0],
                                    1'b1, 1'b0));
        send_access(make_access(FUNC_VICTIM, 12'hFFF, 4'd0, 2'd0, 1'b0, 1'b0));
        send_access(make_access(FUNC_VICTIM, 12'hFFF, 4'd0, 2'd0, 1'b0, 1'b0));
        wait_results_drained();
    endtask

    // Four dueling policies, thread-aware leader and follower fills
    task automatic test_four_policy();
        int n;
        write_policy_mode(1'b1);
        send_access(make_access(FUNC_UPDATE, 12'h003, hand_pos[12'h003], 2'd0, 1'b0, 1'b0));
        send_access(make_access(FUNC_UPDATE, 12'h003, hand_pos[12'h003], 2'd1, 1'b0, 1'b0));
        send_access(make_access(FUNC_UPDATE, 12'h001, hand_pos[12'h001], 2'd2, 1'b0, 1'b0));
        send_access(make_access(FUNC_UPDATE, 12'h002, hand_pos[12'h002], 2'd3, 1'b0, 1'b0));
        send_access(make_access(FUNC_UPDATE, 12'h123, hand_pos[12'h123], 2'd0, 1'b0, 1'b0));
        send_access(make_access(FUNC_VICTIM, 12'h003, 4'd0, 2'd0, 1'b0, 1'b0));
        for (n = 0; n < 150; n++) send_access(random_access(50));
        wait_results_drained();
    endtask

    // Drive the policy 0 leader score into its upper limit
    task automatic test_score_saturation();
        int n;
        logic [SET_W-1:0] s;
        n = 0;
        while ((duel_score[POL_CLOCK] < int'(PSCORE_MAX) - 1) && n < 600) begin
            s = leader_set(int'(POL_CLOCK));
            send_access(make_access(FUNC_UPDATE, s, hand_pos[s], TID_W'($urandom_range(3)),
                                    1'b0, 1'b0));
            n++;
        end
        for (n = 0; n < 8; n++) begin
            s = leader_set(int'(POL_CLOCK));
            send_access(make_access(FUNC_UPDATE, s, hand_pos[s], TID_W'($urandom_range(3)),
                                    1'b0, 1'b0));
        end
        wait_results_drained();
    endtask

    // Random traffic under each idling mix, alternating the policy mode
    task automatic test_random_traffic();
        int p;
        int n;
        for (p = 0; p < 4; p++) begin
            case (p)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            write_policy_mode(p[0]);
            for (n = 0; n < 170; n++) send_access(random_access(30));
            wait_results_drained();
        end
    endtask

    // Keep offering items while the receiver holds off
    task automatic test_backpressure();
        int n;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_req   = 1'b1;
        for (n = 0; n < 40; n++) send_access(random_access(30));
        wait_results_drained();
    endtask

    initial begin
        for (int i = 0; i < HOT_SETS; i++)
            hot_sets[i] = (i < 8) ? leader_set(i % 4) : SET_W'($urandom_range(4095));
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Wait out the set RAM clear
        do @(posedge i_clk); while (!s_axis_tready);

        test_clock_sweep();
        test_four_policy();
        test_score_saturation();
        test_random_traffic();
        test_backpressure();

        if (mismatch_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

// File: clock_replacement_set_dueling_core.f
design/crsd_pkg.sv
design/crsd_ram.sv
design/crsd_set_ctl.sv
design/crsd_duel.sv
design/clock_replacement_set_dueling_core.sv
sim/testbench.sv
